// ===== rtl/abscc_pkg.sv =====
// Shared types and constants for the analog button state classifier.
package abscc_pkg;

   localparam int BUTTONS    = 4;
   localparam int SAMPLES    = 8;
   localparam int IDX_W      = 2;
   localparam int RAW_W      = 12;
   localparam int VDDA_W     = 10;
   localparam int PROD_W     = RAW_W + VDDA_W;
   localparam int V_W        = VDDA_W;
   localparam int CNT_W      = 5;
   localparam int HOLD_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;
   localparam int FULL_SCALE = 4095;

   // queue depth must stay a power of two: the pointers wrap by overflow
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_VDDA_SCALE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_HIGH_MASK  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_MASK   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_MIN_LOWS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STUCK_LIMIT_SHORT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STUCK_LIMIT_LONG  = 3'd5;

   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_HIGH,
      CLS_LOW,
      CLS_SHORT
   } class_type;

   typedef enum logic [2:0] {
      ST_NOT_PRESSED,
      ST_PRESSED,
      ST_RELEASED,
      ST_STUCK,
      ST_SHORT
   } status_type;

   typedef struct packed {
      logic [VDDA_W-1:0]  vdda_scale;
      logic [BUTTONS-1:0] active_high_mask;
      logic [BUTTONS-1:0] long_press_mask;
      logic [4:0]         release_min_lows;
      logic [7:0]         stuck_limit_short;
      logic [6:0]         stuck_limit_long;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0] button_index;
      class_type        cls;
   } entry_type;

endpackage

// ===== rtl/abscc_req_if.sv =====
// Request channel: button index and raw ADC sample.
interface abscc_req_if;
   logic                         valid;
   logic                         ready;
   logic [abscc_pkg::IDX_W-1:0]  button_index;
   logic [abscc_pkg::RAW_W-1:0]  raw_sample;

   modport source (output valid, button_index, raw_sample, input ready);
   modport sink (input valid, button_index, raw_sample, output ready);
endinterface

// ===== rtl/abscc_rsp_if.sv =====
// Response channel: window flag and button status.
interface abscc_rsp_if;
   logic       valid;
   logic       ready;
   logic       window_done;
   logic [2:0] button_status;

   modport source (output valid, window_done, button_status, input ready);
   modport sink (input valid, window_done, button_status, output ready);
endinterface

// ===== rtl/analog_button_state_classifier_core.sv =====
// Path: a transaction passes the stage 1 and stage 2 registers, the queue and the
//   result register in that order. Throughput: one sample per cycle while the response
//   channel accepts results; the front stages, a 4-entry queue and the back end each handle a sample every cycle.
// Reset (synchronous): configuration returns to its defaults, all per-button
//   counts and press state clear, pipeline and queue empty.
// Top level: configuration registers, front end, queue and back end.
module analog_button_state_classifier_core (
   input  logic                                  clock,
   input  logic                                  reset,
   abscc_req_if.sink                             req_chan,
   abscc_rsp_if.source                           rsp_chan,
   input  logic                                  csr_wr_en,
   input  logic [abscc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [abscc_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   abscc_pkg::cfg_type   cfg_ff;
   logic                 push_valid;
   abscc_pkg::entry_type push_entry;
   logic                 q_full;
   logic                 head_valid;
   abscc_pkg::entry_type head_entry;
   logic                 head_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vdda_scale        <= 10'd330;
         cfg_ff.active_high_mask  <= '0;
         cfg_ff.long_press_mask   <= '0;
         cfg_ff.release_min_lows  <= 5'd4;
         cfg_ff.stuck_limit_short <= 8'd10;
         cfg_ff.stuck_limit_long  <= 7'd10;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            abscc_pkg::CSR_VDDA_SCALE:        cfg_ff.vdda_scale        <= csr_wr_data;
            abscc_pkg::CSR_ACTIVE_HIGH_MASK:  cfg_ff.active_high_mask  <= csr_wr_data[3:0];
            abscc_pkg::CSR_LONG_PRESS_MASK:   cfg_ff.long_press_mask   <= csr_wr_data[3:0];
            abscc_pkg::CSR_RELEASE_MIN_LOWS:  cfg_ff.release_min_lows  <= csr_wr_data[4:0];
            abscc_pkg::CSR_STUCK_LIMIT_SHORT: cfg_ff.stuck_limit_short <= csr_wr_data[7:0];
            abscc_pkg::CSR_STUCK_LIMIT_LONG:  cfg_ff.stuck_limit_long  <= csr_wr_data[6:0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   abscc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   abscc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .pop_valid  (head_valid),
      .pop_entry  (head_entry),
      .pop_ready  (head_ready)
   );

   abscc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_ready (head_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== rtl/abscc_front.sv =====
// Front end: scales each sample to the supply range and classifies it.
module abscc_front (
   input  logic                 clock,
   input  logic                 reset,
   abscc_req_if.sink            req_chan,
   input  abscc_pkg::cfg_type   cfg,
   input  logic                 q_full,
   output logic                 push_valid,
   output abscc_pkg::entry_type push_entry
);

   // stage 1: product
   logic                               s1_valid_ff;
   logic [abscc_pkg::PROD_W-1:0]       s1_prod_ff;
   logic [abscc_pkg::IDX_W-1:0]        s1_idx_ff;
   logic                               s1_ah_ff;
   logic [abscc_pkg::VDDA_W-1:0]       s1_vdda_ff;
   logic                               s1_ready;

   // stage 2: classified entry
   logic                               s2_valid_ff;
   abscc_pkg::entry_type               s2_entry_ff;
   abscc_pkg::entry_type               s2_entry_in;
   logic                               s2_ready;

   logic [abscc_pkg::V_W-1:0]          q_est;
   logic [abscc_pkg::RAW_W:0]          rem;
   logic [abscc_pkg::V_W-1:0]          v;
   logic [19:0]                        v10;
   logic [19:0]                        v1000;
   logic [19:0]                        vdda6;
   logic [19:0]                        vdda4;
   logic [19:0]                        vdda109;
   logic                               v_le_vdda;

   assign s2_ready       = !s2_valid_ff || !q_full;
   assign s1_ready       = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready;
   assign push_valid     = s2_valid_ff;
   assign push_entry     = s2_entry_ff;

   // floor(p / 4095): estimate with p >> 12, then one correction step
   always_comb begin
      q_est = s1_prod_ff[abscc_pkg::PROD_W-1:abscc_pkg::RAW_W];
      rem   = {1'b0, s1_prod_ff[abscc_pkg::RAW_W-1:0]}
              + {{(abscc_pkg::RAW_W+1-abscc_pkg::V_W){1'b0}}, q_est};
      v     = q_est + ((rem >= 13'(abscc_pkg::FULL_SCALE)) ? 10'd1 : 10'd0);
   end

   always_comb begin
      v10       = 20'(v) * 20'd10;
      v1000     = 20'(v) * 20'd1000;
      vdda6     = 20'(s1_vdda_ff) * 20'd6;
      vdda4     = 20'(s1_vdda_ff) * 20'd4;
      vdda109   = 20'(s1_vdda_ff) * 20'd109;
      v_le_vdda = v <= s1_vdda_ff;
      s2_entry_in.button_index = s1_idx_ff;
      s2_entry_in.cls          = abscc_pkg::CLS_NONE;
      if (s1_ah_ff) begin
         if (v_le_vdda && v10 > vdda6) begin
            s2_entry_in.cls = abscc_pkg::CLS_HIGH;
         end else if (v10 < vdda4) begin
            s2_entry_in.cls = abscc_pkg::CLS_LOW;
         end
      end else begin
         if (v != '0 && v1000 < vdda109) begin
            s2_entry_in.cls = abscc_pkg::CLS_HIGH;
         end else if (v == '0) begin
            s2_entry_in.cls = abscc_pkg::CLS_SHORT;
         end else if (v_le_vdda && v10 > vdda6) begin
            s2_entry_in.cls = abscc_pkg::CLS_LOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
      if (s1_ready && req_chan.valid) begin
         s1_prod_ff <= abscc_pkg::PROD_W'(req_chan.raw_sample) *
                       abscc_pkg::PROD_W'(cfg.vdda_scale);
         s1_idx_ff  <= req_chan.button_index;
         s1_ah_ff   <= cfg.active_high_mask[req_chan.button_index];
         s1_vdda_ff <= cfg.vdda_scale;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_entry_ff <= s2_entry_in;
      end
   end

endmodule

// ===== rtl/abscc_queue.sv =====
// Short FIFO between the classifier front end and the decision back end.
module abscc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  abscc_pkg::entry_type push_entry,
   output logic                 full,
   output logic                 pop_valid,
   output abscc_pkg::entry_type pop_entry,
   input  logic                 pop_ready
);

   abscc_pkg::entry_type            entry_ff [abscc_pkg::QUEUE_DEPTH];
   logic [abscc_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [abscc_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [abscc_pkg::QCNT_W-1:0]    count_ff;
   logic                            do_push;
   logic                            do_pop;

   assign full      = count_ff == abscc_pkg::QCNT_W'(abscc_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_entry = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/abscc_back.sv =====
// Back end: per-button window counts, press decision and result register.
module abscc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  abscc_pkg::cfg_type   cfg,
   input  logic                 head_valid,
   input  abscc_pkg::entry_type head_entry,
   output logic                 head_ready,
   abscc_rsp_if.source          rsp_chan
);

   localparam int CW = abscc_pkg::CNT_W;
   localparam int HW = abscc_pkg::HOLD_W;

   logic [CW-1:0] sample_cnt_ff [abscc_pkg::BUTTONS];
   logic [CW-1:0] high_cnt_ff   [abscc_pkg::BUTTONS];
   logic [CW-1:0] low_cnt_ff    [abscc_pkg::BUTTONS];
   logic [CW-1:0] short_cnt_ff  [abscc_pkg::BUTTONS];
   logic [HW-1:0] hold_cnt_ff   [abscc_pkg::BUTTONS];
   logic          last_ff       [abscc_pkg::BUTTONS];

   logic                        rsp_valid_ff;
   logic                        rsp_done_ff;
   abscc_pkg::status_type       rsp_status_ff;

   logic [abscc_pkg::IDX_W-1:0] b;
   logic                        fire;
   logic [CW-1:0]               hi_in;
   logic [CW-1:0]               lo_in;
   logic [CW-1:0]               sh_in;
   logic                        window;
   logic                        all_high;
   logic                        all_short;
   logic                        release_hit;
   logic [HW-1:0]               hold;
   logic [HW:0]                 hold_p1;
   logic [HW:0]                 two_l;
   logic                        stuck_s;
   logic                        stuck_l;
   logic [HW-1:0]               hold_in;
   logic                        last_in;
   abscc_pkg::status_type       status;

   assign head_ready             = !rsp_valid_ff || rsp_chan.ready;
   assign fire                   = head_valid && head_ready;
   assign b                      = head_entry.button_index;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.window_done   = rsp_done_ff;
   assign rsp_chan.button_status = rsp_status_ff;

   always_comb begin
      hi_in = high_cnt_ff[b] + ((head_entry.cls == abscc_pkg::CLS_HIGH) ? 5'd1 : 5'd0);
      lo_in = low_cnt_ff[b] + ((head_entry.cls == abscc_pkg::CLS_LOW) ? 5'd1 : 5'd0);
      sh_in = short_cnt_ff[b] + ((head_entry.cls == abscc_pkg::CLS_SHORT) ? 5'd1 : 5'd0);
      window      = sample_cnt_ff[b] == CW'(abscc_pkg::SAMPLES - 1);
      all_high    = hi_in == CW'(abscc_pkg::SAMPLES);
      all_short   = sh_in == CW'(abscc_pkg::SAMPLES);
      release_hit = lo_in <= CW'(abscc_pkg::SAMPLES) && lo_in > cfg.release_min_lows
                    && last_ff[b];
      hold        = hold_cnt_ff[b];
      hold_p1     = {1'b0, hold} + 9'd1;
      two_l       = {1'b0, cfg.stuck_limit_long, 1'b0};
      // a zero limit never matches: the compare is gated off when the limit is zero
      stuck_s     = cfg.stuck_limit_short != '0 && hold == cfg.stuck_limit_short - 8'd1;
      stuck_l     = cfg.stuck_limit_long != '0 && hold_p1 == two_l;

      hold_in = '0;
      last_in = 1'b0;
      status  = abscc_pkg::ST_NOT_PRESSED;
      if (!cfg.long_press_mask[b]) begin
         if (all_high && !stuck_s) begin
            hold_in = hold_p1[HW-1:0];
            last_in = 1'b1;
            status  = abscc_pkg::ST_PRESSED;
         end else if (release_hit) begin
            status = abscc_pkg::ST_RELEASED;
         end else if (all_short) begin
            status = abscc_pkg::ST_SHORT;
         end else if (all_high) begin
            status = abscc_pkg::ST_STUCK;
         end
      end else begin
         if (all_high && hold == '0 && cfg.stuck_limit_long > 7'd1) begin
            hold_in = 8'd1;
         end else if (all_high && hold != '0 && hold_p1 < two_l) begin
            hold_in = hold_p1[HW-1:0];
            last_in = 1'b1;
            status  = abscc_pkg::ST_PRESSED;
         end else if (release_hit) begin
            status = abscc_pkg::ST_RELEASED;
         end else if (all_short) begin
            status = abscc_pkg::ST_SHORT;
         end else if (all_high && stuck_l) begin
            status = abscc_pkg::ST_STUCK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < abscc_pkg::BUTTONS; i++) begin
            sample_cnt_ff[i] <= '0;
            high_cnt_ff[i]   <= '0;
            low_cnt_ff[i]    <= '0;
            short_cnt_ff[i]  <= '0;
            hold_cnt_ff[i]   <= '0;
            last_ff[i]       <= 1'b0;
         end
      end else begin
         if (head_ready) begin
            rsp_valid_ff <= head_valid;
         end
         if (fire) begin
            if (window) begin
               sample_cnt_ff[b] <= '0;
               high_cnt_ff[b]   <= '0;
               low_cnt_ff[b]    <= '0;
               short_cnt_ff[b]  <= '0;
               hold_cnt_ff[b]   <= hold_in;
               last_ff[b]       <= last_in;
            end else begin
               sample_cnt_ff[b] <= sample_cnt_ff[b] + 5'd1;
               high_cnt_ff[b]   <= hi_in;
               low_cnt_ff[b]    <= lo_in;
               short_cnt_ff[b]  <= sh_in;
            end
         end
      end
      if (fire) begin
         rsp_done_ff <= window;
         if (window) begin
            rsp_status_ff <= status;
         end else begin
            rsp_status_ff <= last_ff[b] ? abscc_pkg::ST_PRESSED : abscc_pkg::ST_NOT_PRESSED;
         end
      end
   end

endmodule
